>>> sv/pvd_pkg.sv
// pvd_pkg: shared constants, opcodes, pair modes and range classification
// for the pixel value differencing embed unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pvd_pkg;

  // Message store depth and the widths that follow from it
  localparam int MSG_BYTES = 256;
  localparam int ADDR_W    = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int COUNT_W   = $clog2(MSG_BYTES + 1);
  localparam int PTR_W     = COUNT_W + 3;

  // Input opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_HEADER = 2'd2;
  localparam logic [1:0] OP_EMBED  = 2'd3;

  // How a pair is treated in the back end
  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_EMBED  = 2'd1;
  localparam logic [1:0] MODE_PASS   = 2'd2;

  typedef struct packed {
    logic [2:0] cap;
    logic [7:0] low;
  } range_t;

  // Difference magnitude to capacity and lower bound
  function automatic range_t classify(input logic [7:0] mag);
    range_t r;
    if (mag <= 8'd7) begin
      r.cap = 3'd3; r.low = 8'd0;
    end else if (mag <= 8'd15) begin
      r.cap = 3'd3; r.low = 8'd8;
    end else if (mag <= 8'd31) begin
      r.cap = 3'd4; r.low = 8'd16;
    end else if (mag <= 8'd63) begin
      r.cap = 3'd5; r.low = 8'd32;
    end else if (mag <= 8'd127) begin
      r.cap = 3'd6; r.low = 8'd64;
    end else begin
      r.cap = 3'd7; r.low = 8'd128;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/pvd_adjust.sv
// pvd_adjust: splits a difference change between the two pixels; embed mode moves
// the pair back into 0..255, pass mode keeps the inputs. Depends on pvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvd_adjust import pvd_pkg::*; (
  input  wire logic [1:0]         mode,
  input  wire logic signed [10:0] change,
  input  wire logic [7:0]         first_in,
  input  wire logic [7:0]         second_in,
  output logic [7:0]              first_adj,
  output logic [7:0]              second_adj
);

  logic signed [10:0] half;
  logic signed [11:0] fa;
  logic signed [11:0] ba;

  always_comb begin
    // truncating halve: bias negatives by one before the arithmetic shift
    half = (change + $signed({10'd0, change[10]})) >>> 1;
    fa = $signed({4'd0, first_in}) - ($signed({change[10], change}) -
                                      $signed({half[10], half}));
    ba = $signed({4'd0, second_in}) + $signed({half[10], half});
    if (mode == MODE_EMBED) begin
      if (fa < 12'sd0) begin
        ba = ba - fa;
        fa = 12'sd0;
      end
      if (fa > 12'sd255) begin
        ba = ba - (fa - 12'sd255);
        fa = 12'sd255;
      end
      if (ba < 12'sd0) begin
        fa = fa - ba;
        ba = 12'sd0;
      end
      if (ba > 12'sd255) begin
        fa = fa - (ba - 12'sd255);
        ba = 12'sd255;
      end
    end
    if (mode == MODE_PASS) begin
      first_adj  = first_in;
      second_adj = second_in;
    end else begin
      first_adj  = fa[7:0];
      second_adj = ba[7:0];
    end
  end

endmodule

`default_nettype wire

>>> sv/pvd_stego_embed_unit.sv
// pvd_stego_embed_unit: top level of the pixel value differencing embedder,
// message store, pointer state and three-stage pair pipeline.
// Depends on pvd_pkg and pvd_adjust.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  input    | in_valid / in_stall | opcode, message_byte, first_pixel,
//           |                     | second_pixel
//  output   | out_valid/out_stall | first_out, second_out, bits_taken,
//           |                     | message_ended, passed_unchanged
//
// One transaction per cycle is accepted while in_stall is low. Pointer, count and
// end flag update in the accept cycle, so every transaction sees the state left
// by the one before it. Header and embed pairs pass stage 1, stage 2 and the
// output register to out_valid; clear and load transactions give no result.
// The message store has one write port and two read ports, so the up to
// seven bits of a pair that span two bytes are fetched together.
// rst clears count, pointer, end flag and stage valid bits; store contents
// are not cleared. While out_stall holds a result, up to two more pairs
// enter the pipeline before in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module pvd_stego_embed_unit import pvd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] message_byte,
  input  wire logic [7:0] first_pixel,
  input  wire logic [7:0] second_pixel,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      first_out,
  output logic [7:0]      second_out,
  output logic [2:0]      bits_taken,
  output logic            message_ended,
  output logic            passed_unchanged
);

  // stage 1: pair captured at accept, store data arrives alongside
  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        first;
    logic [7:0]        second;
    logic signed [8:0] diff;
    logic [7:0]        low;
    logic [2:0]        taken;
    logic [2:0]        offset;
    logic              ended;
    logic [7:0]        count8;
  } stage1_t;

  // stage 2: difference change ready for split and fix-ups
  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         first;
    logic [7:0]         second;
    logic signed [10:0] change;
    logic [2:0]         taken;
    logic               ended;
  } stage2_t;

  // message store and pointer state
  logic [7:0]         store [MSG_BYTES];
  logic [COUNT_W-1:0] byte_count;
  logic [PTR_W-1:0]   bit_pointer;
  logic               finished;

  logic [7:0] rd_hi;
  logic [7:0] rd_lo;

  stage1_t s1;
  stage2_t s2;
  stage1_t s1_next;
  stage2_t s2_next;
  logic    v1;
  logic    v2;

  // pipeline flow
  logic accept;
  logic adv2;
  logic adv3;
  logic load2;
  logic load3;
  logic pair_in;

  assign adv3     = !out_valid || !out_stall;
  assign load3    = v2 && adv3;
  assign adv2     = !v2 || adv3;
  assign load2    = v1 && adv2;
  assign in_stall = v1 && !adv2;
  assign accept   = in_valid && !in_stall;
  assign pair_in  = accept && (opcode == OP_HEADER || opcode == OP_EMBED);

  // accept-cycle classification and bit budget
  logic signed [8:0]  diff0;
  logic [7:0]         mag0;
  range_t             rng0;
  logic [PTR_W-1:0]   total0;
  logic [PTR_W-1:0]   remain0;
  logic [2:0]         taken0;
  logic               ended0;
  logic [COUNT_W-1:0] idx0;
  logic [COUNT_W:0]   idx0_inc;
  logic [ADDR_W-1:0]  addr_hi;
  logic [ADDR_W-1:0]  addr_lo;

  always_comb begin
    diff0   = $signed({1'b0, second_pixel}) - $signed({1'b0, first_pixel});
    mag0    = diff0[8] ? 8'(-diff0) : diff0[7:0];
    rng0    = classify(mag0);
    total0  = {byte_count, 3'b000};
    remain0 = (bit_pointer < total0) ? (total0 - bit_pointer) : '0;
    if (remain0 < PTR_W'(rng0.cap)) begin
      taken0 = remain0[2:0];
      ended0 = 1'b1;
    end else begin
      taken0 = rng0.cap;
      ended0 = 1'b0;
    end
    // bytes holding the next bits; out-of-range fetches are never used
    idx0     = bit_pointer[PTR_W-1:3];
    idx0_inc = {1'b0, idx0} + 1'b1;
    addr_hi  = (idx0 < COUNT_W'(MSG_BYTES)) ? idx0[ADDR_W-1:0] : '0;
    addr_lo  = (idx0_inc < (COUNT_W + 1)'(MSG_BYTES)) ? idx0_inc[ADDR_W-1:0] : '0;

    s1_next.first  = first_pixel;
    s1_next.second = second_pixel;
    s1_next.diff   = diff0;
    s1_next.low    = rng0.low;
    s1_next.offset = bit_pointer[2:0];
    s1_next.count8 = 8'(byte_count);
    if (opcode == OP_HEADER) begin
      s1_next.mode  = MODE_HEADER;
      s1_next.taken = 3'd0;
      s1_next.ended = 1'b0;
    end else if (finished) begin
      s1_next.mode  = MODE_PASS;
      s1_next.taken = 3'd0;
      s1_next.ended = 1'b0;
    end else begin
      s1_next.mode  = MODE_EMBED;
      s1_next.taken = taken0;
      s1_next.ended = ended0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      bit_pointer <= '0;
      finished    <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        unique case (opcode)
          OP_CLEAR: begin
            byte_count  <= '0;
            bit_pointer <= '0;
            finished    <= 1'b0;
          end
          OP_LOAD: begin
            if (byte_count < COUNT_W'(MSG_BYTES)) begin
              byte_count <= byte_count + 1'b1;
            end
          end
          OP_HEADER: begin
          end
          OP_EMBED: begin
            if (!finished) begin
              bit_pointer <= bit_pointer + PTR_W'(taken0);
              if (ended0) begin
                finished <= 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (pair_in) begin
        v1 <= 1'b1;
      end else if (adv2) begin
        v1 <= 1'b0;
      end
      if (load2) begin
        v2 <= 1'b1;
      end else if (adv3) begin
        v2 <= 1'b0;
      end
      if (load3) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_LOAD && byte_count < COUNT_W'(MSG_BYTES)) begin
      store[byte_count[ADDR_W-1:0]] <= message_byte;
    end
    if (pair_in) begin
      rd_hi <= store[addr_hi];
      rd_lo <= store[addr_lo];
      s1    <= s1_next;
    end
  end

  // stage 1 -> 2: extract message value, form the difference change
  logic [15:0]        window;
  logic [15:0]        window_sh;
  logic [6:0]         value1;
  logic [8:0]         dec_mag;
  logic signed [9:0]  dec1;

  always_comb begin
    window    = {rd_hi, rd_lo};
    window_sh = window << s1.offset;
    value1    = window_sh[15:9] >> (3'd7 - s1.taken);
    dec_mag   = {2'b00, value1} + {1'b0, s1.low};
    dec1      = s1.diff[8] ? -$signed({1'b0, dec_mag}) : $signed({1'b0, dec_mag});
    s2_next.mode   = s1.mode;
    s2_next.first  = s1.first;
    s2_next.second = s1.second;
    s2_next.taken  = s1.taken;
    s2_next.ended  = s1.ended;
    if (s1.mode == MODE_HEADER) begin
      s2_next.change = $signed({3'b000, s1.count8}) - $signed({{2{s1.diff[8]}}, s1.diff});
    end else begin
      s2_next.change = $signed({dec1[9], dec1}) - $signed({{2{s1.diff[8]}}, s1.diff});
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      s2 <= s2_next;
    end
  end

  // stage 2 -> output: split and fix-ups
  logic [7:0] first_adj;
  logic [7:0] second_adj;

  pvd_adjust u_adjust (
    .mode       (s2.mode),
    .change     (s2.change),
    .first_in   (s2.first),
    .second_in  (s2.second),
    .first_adj  (first_adj),
    .second_adj (second_adj)
  );

  always_ff @(posedge clk) begin
    if (load3) begin
      first_out        <= first_adj;
      second_out       <= second_adj;
      bits_taken       <= s2.taken;
      message_ended    <= s2.ended;
      passed_unchanged <= (s2.mode == MODE_PASS);
    end
  end

  // checks
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    bit_pointer <= {byte_count, 3'b000})
    else $error("bit pointer ran past the loaded message");

  a_pass_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_EMBED && finished) |=> (v1 && s1.mode == MODE_PASS))
    else $error("pair after message end not marked for pass-through");

  a_end_short: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_ended) |-> (bits_taken != 3'd7 && !passed_unchanged))
    else $error("ending pair carried a full seven bits or was passed");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && out_valid))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// testbench: self-checking bench for pvd_stego_embed_unit, with its own pixel pair
// predictor, a queue-fed driver, a monitor and random idling on both channels.
// Depends on pvd_pkg and the RTL of pvd_stego_embed_unit.
`timescale 1ns / 1ps

module testbench;
  import pvd_pkg::*;

  // One input transaction as queued for the driver
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] mbyte;
    logic [7:0] px_a;
    logic [7:0] px_b;
  } pvd_cmd_t;

  // One predicted output transaction
  typedef struct packed {
    logic [7:0] first_px;
    logic [7:0] second_px;
    logic [2:0] taken;
    logic       ended;
    logic       passed;
  } pair_result_t;

  localparam int IDLE_LIMIT   = 4000;  // cycles with no transaction on either side
  localparam int RANDOM_ITEMS = 500;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] opcode = OP_CLEAR;
  logic [7:0] message_byte = 8'd0;
  logic [7:0] first_pixel = 8'd0;
  logic [7:0] second_pixel = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] first_out;
  logic [7:0] second_out;
  logic [2:0] bits_taken;
  logic       message_ended;
  logic       passed_unchanged;

  pvd_stego_embed_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .message_byte     (message_byte),
    .first_pixel      (first_pixel),
    .second_pixel     (second_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .first_out        (first_out),
    .second_out       (second_out),
    .bits_taken       (bits_taken),
    .message_ended    (message_ended),
    .passed_unchanged (passed_unchanged)
  );

  // Stimulus and scoreboard storage
  pvd_cmd_t     cmd_queue[$];
  pair_result_t expected_pairs[$];
  pvd_cmd_t     cur_cmd;
  pair_result_t want;

  // Predictor state: message bytes, byte count, read position, end-of-message flag
  logic [7:0] msg_mem [MSG_BYTES];
  int         msg_count = 0;
  int         read_pos = 0;
  bit         msg_done = 1'b0;

  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit in_taken = 1'b0;
  int in_gap = 0;
  int in_calm = 0;
  int stall_left = 0;
  int out_calm = 0;
  int random_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Prints one line per mismatch and counts it
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Gap length: mostly zero or short, a few long; occasional calm stretches
  // with no gaps at all
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Split a difference change between the two pixels, rounding toward zero
  function automatic void split_delta(input int delta, inout int p, inout int q);
    int half;
    half = delta / 2;
    if (delta % 2 == 0) p -= half;
    else if (delta >= 0) p -= half + 1;
    else p -= half - 1;
    q += half;
  endfunction

  // Applies one accepted transaction to the predictor state and queues the
  // expected pair, if the opcode yields one
  task automatic predict_pair(input logic [1:0] op, input logic [7:0] mb,
                              input logic [7:0] a, input logic [7:0] b);
    int p, q, diff, mag, cap, low, total, remain, value, dec, pos;
    pair_result_t r;
    p = int'(a);
    q = int'(b);
    r = '0;
    case (op)
      OP_CLEAR: begin
        msg_count = 0;
        read_pos = 0;
        msg_done = 1'b0;
      end
      OP_LOAD: begin
        if (msg_count < MSG_BYTES) begin
          msg_mem[msg_count] = mb;
          msg_count++;
        end
      end
      OP_HEADER: begin
        // difference becomes the byte count mod 256, no fix-ups, pixels wrap
        split_delta((msg_count % 256) - (q - p), p, q);
      end
      default: begin
        if (msg_done) begin
          r.passed = 1'b1;
        end else begin
          diff = q - p;
          mag = (diff < 0) ? -diff : diff;
          if (mag <= 7) begin cap = 3; low = 0; end
          else if (mag <= 15) begin cap = 3; low = 8; end
          else if (mag <= 31) begin cap = 4; low = 16; end
          else if (mag <= 63) begin cap = 5; low = 32; end
          else if (mag <= 127) begin cap = 6; low = 64; end
          else begin cap = 7; low = 128; end
          total = msg_count * 8;
          remain = (read_pos < total) ? total - read_pos : 0;
          // short of capacity (or empty): take what is left and end the message
          if (remain < cap) begin
            cap = remain;
            r.ended = 1'b1;
          end
          value = 0;
          for (int k = 0; k < cap; k++) begin
            pos = read_pos + k;
            value = (value << 1) | int'(msg_mem[pos >> 3][7 - (pos & 7)]);
          end
          read_pos += cap;
          if (r.ended) msg_done = 1'b1;
          dec = value + low;
          if (diff < 0) dec = -dec;
          split_delta(dec - diff, p, q);
          // ordered fix-ups back into 0..255
          if (p < 0) begin q -= p; p = 0; end
          if (p > 255) begin q -= p - 255; p = 255; end
          if (q < 0) begin p -= q; q = 0; end
          if (q > 255) begin p -= q - 255; q = 255; end
          r.taken = cap[2:0];
        end
      end
    endcase
    if (op == OP_HEADER || op == OP_EMBED) begin
      r.first_px = p[7:0];
      r.second_px = q[7:0];
      expected_pairs = {expected_pairs, r};
    end
  endtask

  task automatic push_cmd(input logic [1:0] op, input logic [7:0] mb,
                          input logic [7:0] a, input logic [7:0] b);
    pvd_cmd_t c;
    c.op = op;
    c.mbyte = mb;
    c.px_a = a;
    c.px_b = b;
    cmd_queue = {cmd_queue, c};
  endtask

  // Pixel pair spread over all six difference ranges, often at the edges of
  // 0..255 so that the fix-ups fire; some pairs fully random
  task automatic rand_pair(output logic [7:0] a, output logic [7:0] b);
    int band, lo, hi, mag, base;
    band = $urandom_range(0, 6);
    if (band == 6) begin
      a = 8'($urandom);
      b = 8'($urandom);
    end else begin
      lo = (band == 0) ? 0 : (8 << (band - 1));
      hi = (band == 0) ? 7 : 2 * lo - 1;
      mag = $urandom_range(lo, hi);
      case ($urandom_range(0, 3))
        0: base = 0;
        1: base = 255 - mag;
        default: base = $urandom_range(0, 255 - mag);
      endcase
      if ($urandom_range(0, 1)) begin
        a = 8'(base);
        b = 8'(base + mag);
      end else begin
        a = 8'(base + mag);
        b = 8'(base);
      end
    end
  endtask

  task automatic push_embed();
    logic [7:0] a, b;
    rand_pair(a, b);
    push_cmd(OP_EMBED, 8'($urandom), a, b);
  endtask

  task automatic push_load(input logic [7:0] mb);
    push_cmd(OP_LOAD, mb, 8'($urandom), 8'($urandom));
  endtask

  // Random message byte, with all-zero and all-one bytes mixed in
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Directed part: empty message, pass-through, load after end, every range,
  // differences of both signs, pixel extremes and headers
  task automatic fill_directed();
    push_cmd(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(OP_HEADER, 8'h00, 8'd0, 8'd255);      // header on empty store
    push_cmd(OP_EMBED, 8'h00, 8'd100, 8'd100);     // no bits left: ends at once
    push_cmd(OP_EMBED, 8'h00, 8'd10, 8'd200);      // passes unchanged
    push_load(8'hA5);                              // appended after the end
    push_cmd(OP_EMBED, 8'hFF, 8'd3, 8'd3);         // still passes
    push_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00);
    push_load(8'hFF);
    push_load(8'h00);
    push_load(8'h5A);
    push_cmd(OP_HEADER, 8'h00, 8'd255, 8'd0);
    push_cmd(OP_EMBED, 8'h00, 8'd0, 8'd0);         // range 0-7
    push_cmd(OP_EMBED, 8'h00, 8'd255, 8'd247);     // range 8-15, negative
    push_cmd(OP_EMBED, 8'h00, 8'd0, 8'd16);        // range 16-31 at the floor
    push_cmd(OP_EMBED, 8'h00, 8'd200, 8'd255);     // range 32-63 at the ceiling
    push_cmd(OP_EMBED, 8'h00, 8'd0, 8'd127);       // range 64-127
    push_cmd(OP_EMBED, 8'h00, 8'd255, 8'd0);       // range 128-255, short: ends
    push_cmd(OP_EMBED, 8'h00, 8'd255, 8'd255);     // passes
    push_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00);
    push_load(8'h80);
    push_cmd(OP_EMBED, 8'h00, 8'd252, 8'd255);     // pair at the upper edge
    push_cmd(OP_EMBED, 8'h00, 8'd4, 8'd0);         // pair at the lower edge
    push_cmd(OP_EMBED, 8'h00, 8'd0, 8'd255);       // two bits left: ends
    push_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00);
  endtask

  // Random part: mostly whole messages (clear, load, embed until the end and a
  // few passes), with noise, broken sequences and one full-store run
  task automatic fill_random();
    int len, pairs, hdr_at;
    bit full_done;
    full_done = 1'b0;
    while (random_count < RANDOM_ITEMS) begin
      if (!full_done && random_count > 100) begin
        full_done = 1'b1;
        push_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
        for (int i = 0; i < MSG_BYTES + 2; i++) push_load(rand_byte());
        // count stops at MSG_BYTES; its low byte in the header is 0
        push_cmd(OP_HEADER, 8'($urandom), 8'($urandom), 8'($urandom));
        for (int i = 0; i < 8; i++) push_embed();
        push_load(rand_byte());                             // store full: ignored
        push_cmd(OP_HEADER, 8'($urandom), 8'($urandom), 8'($urandom));
        random_count += MSG_BYTES + 12;
      end else if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 9))
          0: len = 0;
          1, 2: len = $urandom_range(5, 12);
          default: len = $urandom_range(1, 4);
        endcase
        // now and then keep appending to a message that is already running
        if ($urandom_range(0, 5) != 0) begin
          push_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
          random_count++;
        end
        for (int i = 0; i < len; i++) push_load(rand_byte());
        pairs = 2 * len + $urandom_range(0, 3);
        // some messages are cut short by the next clear
        if ($urandom_range(0, 7) == 0) pairs = $urandom_range(0, pairs);
        hdr_at = $urandom_range(0, 2 * pairs + 1);
        for (int i = 0; i < pairs; i++) begin
          if (i == hdr_at) begin
            push_cmd(OP_HEADER, 8'($urandom), 8'($urandom), 8'($urandom));
            random_count++;
          end
          push_embed();
        end
        random_count += len + pairs;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          push_cmd(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        random_count += len;
      end
    end
  endtask

  // Input driver: presents the next queued transaction at the falling edge once
  // the previous one was taken; payload holds while stalled
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (cmd_queue.size() > 0) begin
        cur_cmd = cmd_queue.pop_front();
        opcode <= cur_cmd.op;
        message_byte <= cur_cmd.mbyte;
        first_pixel <= cur_cmd.px_a;
        second_pixel <= cur_cmd.px_b;
        in_valid <= 1'b1;
        in_gap = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure: random stall bursts, mostly short
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(out_calm);
    end
  end

  // Monitor: predicts on input acceptance, checks each output transaction
  // against the oldest expectation, and runs the idle watchdog
  always @(posedge clk) begin
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_taken) predict_pair(opcode, message_byte, first_pixel, second_pixel);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_pairs.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected: %0d %0d",
                                    results_seen, first_out, second_out));
        end else begin
          want = expected_pairs.pop_front();
          if (first_out !== want.first_px)
            report_mismatch($sformatf("result %0d first_out %0d, expected %0d",
                                      results_seen, first_out, want.first_px));
          if (second_out !== want.second_px)
            report_mismatch($sformatf("result %0d second_out %0d, expected %0d",
                                      results_seen, second_out, want.second_px));
          if (bits_taken !== want.taken)
            report_mismatch($sformatf("result %0d bits_taken %0d, expected %0d",
                                      results_seen, bits_taken, want.taken));
          if (message_ended !== want.ended)
            report_mismatch($sformatf("result %0d message_ended %0b, expected %0b",
                                      results_seen, message_ended, want.ended));
          if (passed_unchanged !== want.passed)
            report_mismatch($sformatf("result %0d passed_unchanged %0b, expected %0b",
                                      results_seen, passed_unchanged, want.passed));
        end
      end
      if (in_taken || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Stimulus build, reset, and end of run
  initial begin
    fill_directed();
    fill_random();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (cmd_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_pairs.size() != 0) @(posedge clk);
    // pipeline is three stages deep; leave room for any stray result
    repeat (12) @(posedge clk);
    if (expected_pairs.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_pairs.size()));
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/pvd_pkg.sv
sv/pvd_adjust.sv
sv/pvd_stego_embed_unit.sv
dv/testbench.sv
